/* hw/rtl/ntpo_pkg.sv */
// ntpo_pkg: shared types, codes and constants for the NTP offset tracker.
// Used by every module under hw/rtl; depends on nothing else.
package ntpo_pkg;

  localparam int unsigned PW = 54;  // signed microsecond product width
  localparam int unsigned DW = 56;  // difference / offset datapath width
  localparam int unsigned UW = 20;  // microsecond fraction width
  localparam int unsigned OW = 63;  // offset and delay port width

  localparam logic [31:0] EPOCH_SHIFT_S = 32'd2208988800;  // 1900 -> 1970
  localparam logic [19:0] US_PER_S      = 20'd1000000;
  localparam logic [10:0] MIN_PKT_LEN   = 11'd48;

  typedef enum logic [1:0] {
    REQ_SEND    = 2'd0,
    REQ_RESP    = 2'd1,
    REQ_TIMEOUT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_UNSYNCED  = 2'd0,
    ST_REQUESTED = 2'd1,
    ST_PARTIAL   = 2'd2,
    ST_SYNCED    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    EV_IGNORED   = 3'd0,
    EV_REQUESTED = 3'd1,
    EV_NO_RESP   = 3'd2,
    EV_RESP_ERR  = 3'd3,
    EV_PARTIAL   = 3'd4,
    EV_SYNCED    = 3'd5,
    EV_SILENT    = 3'd6
  } event_t;

  typedef enum logic [1:0] {
    CFG_SYNC_THR = 2'd0,
    CFG_ACCURACY = 2'd1,
    CFG_FAST_IVL = 2'd2,
    CFG_LONG_IVL = 2'd3
  } cfg_idx_t;

  // Control carried alongside the datapath to the decision stage
  typedef struct packed {
    logic [1:0] req_type;
    logic       len_ok;
  } ctl_t;

  typedef struct packed {
    logic [19:0] sync_thr;
    logic [19:0] accuracy;
    logic [31:0] fast_ivl;
    logic [31:0] long_ivl;
  } cfg_t;

  // Whole-second and fraction parts of T1..T4, in microseconds
  typedef struct packed {
    logic [PW-1:0] s1;
    logic [PW-1:0] s2;
    logic [PW-1:0] s3;
    logic [PW-1:0] s4;
    logic [UW-1:0] u1;
    logic [UW-1:0] u2;
    logic [UW-1:0] u3;
    logic [UW-1:0] u4;
  } prod_t;

endpackage

/* hw/rtl/ntpo_conv.sv */
// ntpo_conv: first pipeline stage, timestamp to microsecond conversion.
// Depends on ntpo_pkg.
module ntpo_conv import ntpo_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  logic [1:0]    i_req_type,
  input  logic [10:0]   i_packet_len,
  input  logic [63:0]   i_t1,
  input  logic [63:0]   i_t2,
  input  logic [63:0]   i_t3,
  input  logic [31:0]   i_t4_sec,
  input  logic [19:0]   i_t4_usec,
  output logic          o_valid,
  input  logic          o_ready,
  output ctl_t          o_ctl,
  output prod_t         o_prod
);

  // Seconds since 1900 to signed microseconds since 1970; zero stays zero
  function automatic logic [PW-1:0] sec_to_us(input logic [31:0] sec);
    logic [PW-1:0] s;
    s = (sec == 32'd0) ? '0 : (PW'(sec) - PW'(EPOCH_SHIFT_S));
    return PW'(s * PW'(US_PER_S));
  endfunction

  // floor(frac * 1e6 / 2^32)
  function automatic logic [UW-1:0] frac_to_us(input logic [31:0] frac);
    logic [51:0] p;
    p = 52'(frac) * 52'(US_PER_S);
    return p[51:32];
  endfunction

  logic  v_r;
  logic  ld;
  ctl_t  ctl_r;
  ctl_t  ctl_nxt;
  prod_t prod_r;
  prod_t prod_nxt;

  assign ld      = !v_r || o_ready;
  assign i_ready = ld;

  always_comb begin
    ctl_nxt.req_type = i_req_type;
    ctl_nxt.len_ok   = (i_packet_len >= MIN_PKT_LEN);
    prod_nxt.s1      = sec_to_us(i_t1[63:32]);
    prod_nxt.s2      = sec_to_us(i_t2[63:32]);
    prod_nxt.s3      = sec_to_us(i_t3[63:32]);
    prod_nxt.s4      = PW'(PW'(i_t4_sec) * PW'(US_PER_S));
    prod_nxt.u1      = frac_to_us(i_t1[31:0]);
    prod_nxt.u2      = frac_to_us(i_t2[31:0]);
    prod_nxt.u3      = frac_to_us(i_t3[31:0]);
    prod_nxt.u4      = i_t4_usec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (ld) begin
      v_r <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld && i_valid) begin
      ctl_r  <= ctl_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign o_valid = v_r;
  assign o_ctl   = ctl_r;
  assign o_prod  = prod_r;

endmodule

/* hw/rtl/ntpo_diff.sv */
// ntpo_diff: second and third pipeline stages, timestamp differences,
// then offset and round-trip delay. Depends on ntpo_pkg.
module ntpo_diff import ntpo_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          i_valid,
  output logic          i_ready,
  input  ctl_t          i_ctl,
  input  prod_t         i_prod,
  output logic          o_valid,
  input  logic          o_ready,
  output ctl_t          o_ctl,
  output logic [DW-1:0] o_offset,
  output logic [DW-1:0] o_delay
);

  // Join whole and fractional microseconds, sign-extended to DW
  function automatic logic [DW-1:0] join_us(input logic [PW-1:0] s,
                                            input logic [UW-1:0] u);
    return {{(DW-PW){s[PW-1]}}, s} + DW'(u);
  endfunction

  logic          v2_r;
  logic          v3_r;
  logic          ld2;
  logic          ld3;
  ctl_t          ctl2_r;
  ctl_t          ctl3_r;
  logic [DW-1:0] d21_nxt;
  logic [DW-1:0] d34_nxt;
  logic [DW-1:0] d21_r;
  logic [DW-1:0] d34_r;
  logic [DW-1:0] sum;
  logic [DW-1:0] rnd;
  logic [DW-1:0] off_nxt;
  logic [DW-1:0] dly_nxt;
  logic [DW-1:0] off_r;
  logic [DW-1:0] dly_r;

  assign ld3     = !v3_r || o_ready;
  assign ld2     = !v2_r || ld3;
  assign i_ready = ld2;

  always_comb begin
    d21_nxt = join_us(i_prod.s2, i_prod.u2) - join_us(i_prod.s1, i_prod.u1);
    d34_nxt = join_us(i_prod.s3, i_prod.u3) - join_us(i_prod.s4, i_prod.u4);
  end

  // Halve with truncation toward zero: bias negatives by one, then shift
  always_comb begin
    sum     = d21_r + d34_r;
    rnd     = sum + DW'(sum[DW-1]);
    off_nxt = {rnd[DW-1], rnd[DW-1:1]};
    dly_nxt = d21_r - d34_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld2) begin
        v2_r <= i_valid;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2 && i_valid) begin
      ctl2_r <= i_ctl;
      d21_r  <= d21_nxt;
      d34_r  <= d34_nxt;
    end
    if (ld3 && v2_r) begin
      ctl3_r <= ctl2_r;
      off_r  <= off_nxt;
      dly_r  <= dly_nxt;
    end
  end

  assign o_valid  = v3_r;
  assign o_ctl    = ctl3_r;
  assign o_offset = off_r;
  assign o_delay  = dly_r;

endmodule

/* hw/rtl/ntpo_track.sv */
// ntpo_track: final stage, sync decision, status state and result register.
// Depends on ntpo_pkg.
module ntpo_track import ntpo_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic          i_valid,
  output logic          i_ready,
  input  ctl_t          i_ctl,
  input  logic [DW-1:0] i_offset,
  input  logic [DW-1:0] i_delay,
  output logic          o_valid,
  input  logic          o_ready,
  output logic [2:0]    o_event_code,
  output logic          o_apply_offset,
  output logic [OW-1:0] o_clk_ofs_us,
  output logic [OW-1:0] o_delay_us,
  output logic [31:0]   o_next_interval_ms,
  output logic [1:0]    o_sync_status
);

  logic          ld;
  logic          take;
  logic          valid_r;
  status_t       status_r;
  status_t       status_nxt;
  logic          was_partial_r;
  logic          was_partial_nxt;
  logic [DW-1:0] mag;
  logic          lt_sec;
  logic          apply;
  logic          partial;
  event_t        ev_nxt;
  event_t        ev_r;
  logic          ap_nxt;
  logic          ap_r;
  logic [DW-1:0] off_nxt;
  logic [DW-1:0] off_r;
  logic [DW-1:0] dly_nxt;
  logic [DW-1:0] dly_r;
  logic [31:0]   ivl_nxt;
  logic [31:0]   ivl_r;

  assign ld      = !valid_r || o_ready;
  assign i_ready = ld;
  assign take    = ld && i_valid;

  always_comb begin
    mag     = i_offset[DW-1] ? (DW'(0) - i_offset) : i_offset;
    lt_sec  = (mag < DW'(US_PER_S));
    apply   = !(lt_sec && (mag < DW'(cfg.sync_thr)));
    partial = !lt_sec || (mag > DW'(cfg.accuracy));
  end

  always_comb begin
    status_nxt      = status_r;
    was_partial_nxt = was_partial_r;
    ev_nxt          = EV_IGNORED;
    ap_nxt          = 1'b0;
    off_nxt         = '0;
    dly_nxt         = '0;
    ivl_nxt         = '0;
    unique case (i_ctl.req_type)
      REQ_SEND: begin
        status_nxt = ST_REQUESTED;
        ev_nxt     = EV_REQUESTED;
      end
      REQ_TIMEOUT: begin
        status_nxt = ST_UNSYNCED;
        ev_nxt     = EV_NO_RESP;
      end
      REQ_RESP: begin
        if (status_r == ST_REQUESTED) begin
          if (!i_ctl.len_ok) begin
            status_nxt = ST_UNSYNCED;
            ev_nxt     = EV_RESP_ERR;
          end else begin
            ap_nxt  = apply;
            off_nxt = i_offset;
            dly_nxt = i_delay;
            if (partial) begin
              status_nxt      = ST_PARTIAL;
              was_partial_nxt = 1'b1;
              ivl_nxt         = cfg.fast_ivl;
              ev_nxt          = apply ? EV_PARTIAL : EV_SILENT;
            end else begin
              status_nxt      = ST_SYNCED;
              was_partial_nxt = 1'b0;
              ivl_nxt         = cfg.long_ivl;
              ev_nxt          = (apply || was_partial_r) ? EV_SYNCED : EV_SILENT;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r       <= 1'b0;
      status_r      <= ST_UNSYNCED;
      was_partial_r <= 1'b0;
    end else begin
      if (ld) begin
        valid_r <= i_valid;
      end
      if (take) begin
        status_r      <= status_nxt;
        was_partial_r <= was_partial_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r  <= ev_nxt;
      ap_r  <= ap_nxt;
      off_r <= off_nxt;
      dly_r <= dly_nxt;
      ivl_r <= ivl_nxt;
    end
  end

  // Status is shown as left by the beat in the result register
  logic [1:0] status_shown_r;

  always_ff @(posedge clk) begin
    if (take) begin
      status_shown_r <= status_nxt;
    end
  end

  assign o_valid            = valid_r;
  assign o_event_code       = ev_r;
  assign o_apply_offset     = ap_r;
  assign o_clk_ofs_us       = {{(OW-DW){off_r[DW-1]}}, off_r};
  assign o_delay_us         = {{(OW-DW){dly_r[DW-1]}}, dly_r};
  assign o_next_interval_ms = ivl_r;
  assign o_sync_status      = status_shown_r;

endmodule

/* hw/rtl/ntp_offset_sync_tracker.sv */
// ntp_offset_sync_tracker: top level of the NTP offset / delay tracker.
// Depends on ntpo_pkg, ntpo_conv, ntpo_diff and ntpo_track.
// Beats pass the conversion, difference, offset/delay and decision stages.
// One beat per cycle unless out_ready stalls it; four registered stages with
// per-stage valids, so bubbles close up while a result waits at the output.
// Reset (rst_n low, synchronous): stages empty, status unsynced,
// partial flag clear, registers back to their default values.
module ntp_offset_sync_tracker import ntpo_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // input events
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_req_type,
  input  logic [10:0]          in_packet_len,
  input  logic [63:0]          in_t1_origin,
  input  logic [63:0]          in_t2_receive,
  input  logic [63:0]          in_t3_transmit,
  input  logic [31:0]          in_t4_sec,
  input  logic [19:0]          in_t4_usec,
  // results
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_code,
  output logic                 out_apply_offset,
  output logic signed [62:0]   out_clk_ofs_us,
  output logic signed [62:0]   out_delay_us,
  output logic [31:0]          out_next_interval_ms,
  output logic [1:0]           out_sync_status,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  // Register file; writes taken in any cycle. The user must write only while
  // the pipe is empty, not checked here, so no stage sees a half-changed set.
  cfg_t cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_thr <= 20'd1000;
      cfg_r.accuracy <= 20'd10000;
      cfg_r.fast_ivl <= 32'd2000;
      cfg_r.long_ivl <= 32'd1800000;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SYNC_THR: cfg_r.sync_thr <= cfg_data[19:0];
        CFG_ACCURACY: cfg_r.accuracy <= cfg_data[19:0];
        CFG_FAST_IVL: cfg_r.fast_ivl <= cfg_data;
        CFG_LONG_IVL: cfg_r.long_ivl <= cfg_data;
      endcase
    end
  end

  // Stage 1: convert each timestamp to whole and fractional microseconds.
  // One constant multiply per part; the sum is left to the next stage.
  logic  s1_valid;
  logic  s1_ready;
  ctl_t  s1_ctl;
  prod_t s1_prod;

  ntpo_conv u_conv (
    .clk          (clk),
    .rst_n        (rst_n),
    .i_valid      (in_valid),
    .i_ready      (in_ready),
    .i_req_type   (in_req_type),
    .i_packet_len (in_packet_len),
    .i_t1         (in_t1_origin),
    .i_t2         (in_t2_receive),
    .i_t3         (in_t3_transmit),
    .i_t4_sec     (in_t4_sec),
    .i_t4_usec    (in_t4_usec),
    .o_valid      (s1_valid),
    .o_ready      (s1_ready),
    .o_ctl        (s1_ctl),
    .o_prod       (s1_prod)
  );

  // Stages 2 and 3: T2-T1 and T3-T4, then offset (halved toward zero)
  // and delay from those two differences.
  logic          s3_valid;
  logic          s3_ready;
  ctl_t          s3_ctl;
  logic [DW-1:0] s3_offset;
  logic [DW-1:0] s3_delay;

  ntpo_diff u_diff (
    .clk      (clk),
    .rst_n    (rst_n),
    .i_valid  (s1_valid),
    .i_ready  (s1_ready),
    .i_ctl    (s1_ctl),
    .i_prod   (s1_prod),
    .o_valid  (s3_valid),
    .o_ready  (s3_ready),
    .o_ctl    (s3_ctl),
    .o_offset (s3_offset),
    .o_delay  (s3_delay)
  );

  // Stage 4: all state lives here, so consecutive beats always see the
  // status left by the one before, even back to back.
  logic [OW-1:0] off_bits;
  logic [OW-1:0] dly_bits;

  ntpo_track u_track (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .i_valid            (s3_valid),
    .i_ready            (s3_ready),
    .i_ctl              (s3_ctl),
    .i_offset           (s3_offset),
    .i_delay            (s3_delay),
    .o_valid            (out_valid),
    .o_ready            (out_ready),
    .o_event_code       (out_event_code),
    .o_apply_offset     (out_apply_offset),
    .o_clk_ofs_us       (off_bits),
    .o_delay_us         (dly_bits),
    .o_next_interval_ms (out_next_interval_ms),
    .o_sync_status      (out_sync_status)
  );

  assign out_clk_ofs_us = $signed(off_bits);
  assign out_delay_us   = $signed(dly_bits);

endmodule

/* hw/rtl/ntpo_checker.sv */
// ntpo_checker: port-level assertions for ntp_offset_sync_tracker, bound in below.
// Depends on ntpo_pkg.
module ntpo_checker import ntpo_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_event_code,
  input logic               out_apply_offset,
  input logic signed [62:0] out_clk_ofs_us,
  input logic signed [62:0] out_delay_us,
  input logic [31:0]        out_next_interval_ms,
  input logic [1:0]         out_sync_status
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_code)
      && $stable(out_clk_ofs_us) && $stable(out_sync_status))
    else $error("result beat changed while stalled");

  // No result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only a good response carries numbers
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_code != EV_PARTIAL && out_event_code != EV_SYNCED
      && out_event_code != EV_SILENT
    |-> !out_apply_offset && out_clk_ofs_us == '0 && out_delay_us == '0
      && out_next_interval_ms == '0)
    else $error("non-response beat carries offset data");

  // A step request is only ever reported, never silent
  a_apply_reported: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_apply_offset
    |-> out_event_code == EV_PARTIAL || out_event_code == EV_SYNCED)
    else $error("clock step without a reporting event");

  // Event and resulting status agree
  a_event_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid
    |-> (out_event_code != EV_REQUESTED || out_sync_status == ST_REQUESTED)
      && (out_event_code != EV_NO_RESP || out_sync_status == ST_UNSYNCED)
      && (out_event_code != EV_RESP_ERR || out_sync_status == ST_UNSYNCED)
      && (out_event_code != EV_PARTIAL || out_sync_status == ST_PARTIAL)
      && (out_event_code != EV_SYNCED || out_sync_status == ST_SYNCED))
    else $error("event code and sync status disagree");

endmodule

bind ntp_offset_sync_tracker ntpo_checker u_ntpo_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_event_code       (out_event_code),
  .out_apply_offset     (out_apply_offset),
  .out_clk_ofs_us       (out_clk_ofs_us),
  .out_delay_us         (out_delay_us),
  .out_next_interval_ms (out_next_interval_ms),
  .out_sync_status      (out_sync_status)
);

/* tb/ntp_offset_sync_tracker_tb.sv */
// Self-checking testbench for ntp_offset_sync_tracker: event beats, result beats, register writes.
// Depends on ntpo_pkg and the RTL under hw/rtl. Its own offset/delay predictor checks every beat.
`timescale 1ns / 1ps

module ntp_offset_sync_tracker_tb;
  import ntpo_pkg::*;

  // Event type that the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint NTP_EPOCH_OFFSET_S = 64'sd2208988800;
  localparam longint US_PER_SEC = 64'sd1000000;
  localparam int STALL_LIMIT = 1000;

  typedef struct {
    event_t      ev;
    logic        apply;
    logic [62:0] off_us;
    logic [62:0] dly_us;
    logic [31:0] ivl_ms;
    status_t     status;
  } ntp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [10:0] in_packet_len = '0;
  logic [63:0] in_t1_origin = '0;
  logic [63:0] in_t2_receive = '0;
  logic [63:0] in_t3_transmit = '0;
  logic [31:0] in_t4_sec = '0;
  logic [19:0] in_t4_usec = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_code;
  logic        out_apply_offset;
  logic signed [62:0] out_clk_ofs_us;
  logic signed [62:0] out_delay_us;
  logic [31:0] out_next_interval_ms;
  logic [1:0]  out_sync_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Shadow copy of the tracker state and its registers
  status_t     trk_status = ST_UNSYNCED;
  logic        trk_was_partial = 1'b0;
  logic [19:0] thr_us = 20'd1000;
  logic [19:0] acc_us = 20'd10000;
  logic [31:0] fast_ms = 32'd2000;
  logic [31:0] slow_ms = 32'd1800000;

  ntp_result_t expected_results[$];
  int errors = 0;
  int n_items = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int stall_cycles = 0;

  ntp_offset_sync_tracker i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_req_type          (in_req_type),
    .in_packet_len        (in_packet_len),
    .in_t1_origin         (in_t1_origin),
    .in_t2_receive        (in_t2_receive),
    .in_t3_transmit       (in_t3_transmit),
    .in_t4_sec            (in_t4_sec),
    .in_t4_usec           (in_t4_usec),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_event_code       (out_event_code),
    .out_apply_offset     (out_apply_offset),
    .out_clk_ofs_us       (out_clk_ofs_us),
    .out_delay_us         (out_delay_us),
    .out_next_interval_ms (out_next_interval_ms),
    .out_sync_status      (out_sync_status),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #2 clk = ~clk;

  // Receiver back-pressure: stall the result channel at the current rate
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
  end

  // Convert a 32.32 NTP stamp to signed microseconds since 1970; zero seconds stay zero
  function automatic longint ntp_stamp_to_us(logic [63:0] ts);
    logic [63:0] prod;
    longint secs;
    prod = {32'd0, ts[31:0]} * 64'd1000000;
    secs = (ts[63:32] != 32'd0) ? longint'({32'd0, ts[63:32]}) - NTP_EPOCH_OFFSET_S : 64'sd0;
    return secs * US_PER_SEC + longint'({32'd0, prod[63:32]});
  endfunction

  // Work out the result of one accepted event and advance the shadow state
  function automatic ntp_result_t predict_event(logic [1:0] kind, logic [10:0] len,
                                                logic [63:0] t1, logic [63:0] t2,
                                                logic [63:0] t3, logic [31:0] t4s,
                                                logic [19:0] t4u);
    ntp_result_t r;
    longint u1, u2, u3, u4, ofs, dly;
    logic [63:0] mag;
    logic partial, report;
    r.ev = EV_IGNORED;
    r.apply = 1'b0;
    r.off_us = '0;
    r.dly_us = '0;
    r.ivl_ms = '0;
    case (kind)
      REQ_SEND: begin
        trk_status = ST_REQUESTED;
        r.ev = EV_REQUESTED;
      end
      REQ_TIMEOUT: begin
        trk_status = ST_UNSYNCED;
        r.ev = EV_NO_RESP;
      end
      REQ_RESP: begin
        // a response nobody asked for leaves everything alone
        if (trk_status == ST_REQUESTED) begin
          if (len < 11'd48) begin
            trk_status = ST_UNSYNCED;
            r.ev = EV_RESP_ERR;
          end else begin
            u1 = ntp_stamp_to_us(t1);
            u2 = ntp_stamp_to_us(t2);
            u3 = ntp_stamp_to_us(t3);
            u4 = longint'({32'd0, t4s}) * US_PER_SEC + longint'({44'd0, t4u});
            ofs = ((u2 - u1) + (u3 - u4)) / 2;
            dly = (u4 - u1) - (u3 - u2);
            mag = (ofs < 0) ? -ofs : ofs;
            r.apply = !((mag < 64'd1000000) && (mag < {44'd0, thr_us}));
            report = r.apply;
            partial = (mag >= 64'd1000000) || (mag > {44'd0, acc_us});
            if (partial) begin
              trk_status = ST_PARTIAL;
              trk_was_partial = 1'b1;
              r.ivl_ms = fast_ms;
            end else begin
              trk_status = ST_SYNCED;
              // recovering from a partial sync is always reported
              if (trk_was_partial) report = 1'b1;
              trk_was_partial = 1'b0;
              r.ivl_ms = slow_ms;
            end
            if (report) r.ev = partial ? EV_PARTIAL : EV_SYNCED;
            else r.ev = EV_SILENT;
            r.off_us = ofs[62:0];
            r.dly_us = dly[62:0];
          end
        end
      end
      default: ;
    endcase
    r.status = trk_status;
    return r;
  endfunction

  // Encode Unix microseconds as an NTP stamp whose fraction decodes back exactly
  function automatic logic [63:0] make_stamp(longint us);
    longint secs, usec, frac;
    secs = us / US_PER_SEC;
    usec = us % US_PER_SEC;
    frac = ((usec <<< 32) + 64'sd999999) / US_PER_SEC;
    return {32'(secs + NTP_EPOCH_OFFSET_S), 32'(frac)};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Choose an offset near the thresholds in force, or well away from them
  function automatic longint pick_offset();
    longint m;
    case ($urandom_range(7, 0))
      0: m = 0;
      1: m = longint'($urandom_range({12'd0, thr_us}, 0));
      2: m = longint'({44'd0, thr_us}) + longint'($urandom_range(2, 0)) - 1;
      3: m = longint'({44'd0, acc_us}) + longint'($urandom_range(2, 0)) - 1;
      4: m = longint'($urandom_range(999999, 0));
      5: m = 64'sd999999 + longint'($urandom_range(2, 0));
      6: m = longint'({32'd0, $urandom()});
      default: m = longint'($urandom_range(200, 0));
    endcase
    if ($urandom_range(1, 0) == 1) m = -m;
    return m;
  endfunction

  // Send one event beat; hold valid and payload until the beat is taken
  task automatic send_event(logic [1:0] kind, logic [10:0] len, logic [63:0] t1,
                            logic [63:0] t2, logic [63:0] t3, logic [31:0] t4s,
                            logic [19:0] t4u);
    ntp_result_t r;
    while ($urandom_range(99, 0) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_packet_len <= len;
    in_t1_origin <= t1;
    in_t2_receive <= t2;
    in_t3_transmit <= t3;
    in_t4_sec <= t4s;
    in_t4_usec <= t4u;
    // ready is stable mid-cycle; a high value means the next edge takes the beat
    do @(negedge clk); while (!in_ready);
    r = predict_event(kind, len, t1, t2, t3, t4s, t4u);
    expected_results.push_back(r);
    if (r.ev != EV_IGNORED) n_items++;
    @(posedge clk);
  endtask

  task automatic send_random(logic [1:0] kind, logic [10:0] len);
    send_event(kind, len, rand64(), rand64(), rand64(), $urandom(), 20'($urandom()));
  endtask

  // Build a consistent exchange with the given offset; skew unbalances the two legs
  task automatic send_good(longint o, logic [10:0] len, int skew);
    longint t1u, t2u, t3u, t4u;
    int leg;
    leg = 3 + $urandom_range(2000, 0);
    t1u = longint'($urandom_range(2000000000, 100000)) * US_PER_SEC
          + longint'($urandom_range(999999, 0));
    t2u = t1u + leg + o;
    t3u = t2u + longint'($urandom_range(1000, 0));
    t4u = t3u + leg + skew - o;
    send_event(REQ_RESP, len, make_stamp(t1u), make_stamp(t2u), make_stamp(t3u),
               32'(t4u / US_PER_SEC), 20'(t4u % US_PER_SEC));
  endtask

  // Drop valid and hold until every expected result has come, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    case (idx)
      CFG_SYNC_THR: thr_us = data[19:0];
      CFG_ACCURACY: acc_us = data[19:0];
      CFG_FAST_IVL: fast_ms = data;
      CFG_LONG_IVL: slow_ms = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all_regs(logic [31:0] thr, logic [31:0] acc, logic [31:0] fast,
                                logic [31:0] slow);
    wait_idle();
    write_reg(CFG_SYNC_THR, thr);
    write_reg(CFG_ACCURACY, acc);
    write_reg(CFG_FAST_IVL, fast);
    write_reg(CFG_LONG_IVL, slow);
    cfg_valid <= 1'b0;
  endtask

  // Every event type and state transition, under the reset register values
  task automatic test_event_handling();
    send_random(REQ_RESP, 11'd48);       // response while unsynced: ignore
    send_random(REQ_UNUSED, 11'h7FF);    // unknown type: ignore
    send_random(REQ_TIMEOUT, 11'd0);
    send_random(REQ_SEND, 11'd0);
    send_random(REQ_SEND, 11'd0);        // repeated request
    send_random(REQ_RESP, 11'd47);       // one byte short
    send_random(REQ_SEND, 11'd0);
    send_good(0, 11'd48, 0);             // inside threshold: silent
    send_random(REQ_SEND, 11'd0);
    send_good(5000, 11'h7FF, 0);         // step, still full sync
    send_random(REQ_SEND, 11'd0);
    send_good(-20000, 11'd48, 0);        // partial
    send_random(REQ_SEND, 11'd0);
    send_good(0, 11'd300, 0);            // back to full after partial: reported
    send_random(REQ_RESP, 11'd100);      // response while synced: ignore
    send_random(REQ_SEND, 11'd0);
    send_good(0, 11'd48, 3);             // odd negative sum truncates toward zero
    send_random(REQ_SEND, 11'd0);
    send_event(REQ_RESP, 11'd48, '0, '0, '0, '0, '0);  // all zero seconds
    send_random(REQ_SEND, 11'd0);
    send_event(REQ_RESP, 11'h7FF, '1, '1, '1, '1, '1); // all ones, usec out of range
    send_random(REQ_SEND, 11'd0);
    // zero seconds with full fraction, and seconds below the epoch shift
    send_event(REQ_RESP, 11'd48, {32'd0, 32'hFFFF_FFFF}, {32'd1, 32'd0},
               {32'h8000_0000, 32'h1234_5678}, 32'd0, 20'd999999);
    send_random(REQ_SEND, 11'd0);
    send_good(1000000, 11'd48, 0);
    send_random(REQ_TIMEOUT, 11'd0);
  endtask

  // Registers at the ends of their ranges, and above them
  task automatic test_register_extremes();
    write_all_regs(32'd0, 32'd0, 32'd0, 32'd0);
    send_random(REQ_SEND, 11'd0);
    send_good(0, 11'd48, 0);             // zero threshold: always step
    send_random(REQ_SEND, 11'd0);
    send_good(1, 11'd48, 0);             // zero accuracy: partial
    write_all_regs(32'd999999, 32'd999999, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_random(REQ_SEND, 11'd0);
    send_good(999998, 11'd48, 0);
    send_random(REQ_SEND, 11'd0);
    send_good(-999999, 11'd48, 0);
    send_random(REQ_SEND, 11'd0);
    send_good(-1000000, 11'd48, 0);
  endtask

  // Mostly request/response exchanges with random content, the rest noise
  task automatic test_random_traffic(int target);
    int start;
    int sel;
    bit paused;
    start = n_items;
    paused = 1'b0;
    while (n_items - start < target) begin
      // once per phase, hold off until the block has drained
      if (!paused && (n_items - start >= target / 2)) begin
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(99, 0) < 70) begin
        send_random(REQ_SEND, 11'($urandom()));
        sel = $urandom_range(99, 0);
        if (sel < 75)
          send_good(pick_offset(), 11'($urandom_range(2047, 48)), int'($urandom_range(6, 0)) - 3);
        else if (sel < 87)
          send_random(REQ_RESP, 11'($urandom_range(47, 0)));
        else if (sel < 95)
          send_random(REQ_TIMEOUT, 11'($urandom()));
      end else begin
        send_random(2'($urandom_range(3, 0)), 11'($urandom()));
      end
    end
  endtask

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(negedge clk) begin : check_results
    ntp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with nothing expected, event %0d", $time, out_event_code);
      end else begin
        want = expected_results.pop_front();
        report_field("event_code", 64'(want.ev), 64'(out_event_code));
        report_field("apply_offset", 64'(want.apply), 64'(out_apply_offset));
        report_field("clk_ofs_us", {1'b0, want.off_us}, {1'b0, out_clk_ofs_us});
        report_field("delay_us", {1'b0, want.dly_us}, {1'b0, out_delay_us});
        report_field("next_interval_ms", 64'(want.ivl_ms), 64'(out_next_interval_ms));
        report_field("sync_status", 64'(want.status), 64'(out_sync_status));
      end
    end
  end

  // Watchdog: end the run if no beat moves on any channel for too long
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    snd_idle_pct = 20;
    rcv_idle_pct = 79;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_event_handling();
    test_register_extremes();

    write_all_regs(32'd500, 32'd20000, $urandom(), $urandom());
    test_random_traffic(125);

    // swap the idling: sender slow, receiver mostly ready
    snd_idle_pct = 79;
    rcv_idle_pct = 20;
    write_all_regs(32'hFFFF_FFFF, 32'd2000, 32'd0, 32'hFFFF_FFFF);
    test_random_traffic(125);

    // no idling on either side, registers back at their defaults
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_all_regs(32'd1000, 32'd10000, 32'd2000, 32'd1800000);
    test_random_traffic(125);

    wait_idle();
    if (errors == 0 && expected_results.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
